>>> hw/rtl/shab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shab_pkg;

   // request codes
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_AVG    = 2'd1;
   localparam logic [1:0] REQ_GRAD   = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP   = 2'd2;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int CELL_W   = 18;
   localparam int GSUM_W   = 23;
   localparam int FACTOR_W = 7;
   localparam int VALUE_W  = 19;
   localparam int ROWS_W   = 8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GRP_DIV,
      ST_AVG_WALK,
      ST_AVG_DRAIN,
      ST_GRD_WALK,
      ST_GRD_RDA,
      ST_GRD_RDB,
      ST_GRD_SUM,
      ST_Q_DIV
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/shab_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module shab_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 32768
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/shab_div.sv
`timescale 1ns / 1ps
`default_nettype none

module shab_div #(
   parameter int DW  = 29,
   parameter int DVW = 11
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire signed [DW-1:0]   dividend,
   input  wire [DVW-1:0]         divisor,
   output logic                  done,
   output logic signed [DW-1:0]  quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVW-1:0]   dvs_ff, dvs_in;
   logic [DVW:0]     rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    res_ff, res_in;
   logic [DVW:0]     rem_sh;
   logic             ge;

   // one quotient bit a cycle, restoring, on magnitudes
   always_comb begin
      rem_sh  = {rem_ff[DVW-1:0], quo_ff[DW-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      if (start) begin
         run_in = 1'b1;
         neg_in = dividend[DW-1];
         cnt_in = '0;
         dvs_in = divisor;
         rem_in = '0;
         quo_in = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      end else if (run_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (~quo_in + 1'b1) : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = signed'(res_ff);

endmodule

`default_nettype wire

>>> hw/rtl/spectrum_history_bin_averager_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                   handshake
// request   req_type, req_sample_i/q, req_last_     start & !busy
//           sample, req_bin_index, req_frame_count
// response  rsp_query_value, rsp_rows_used          rsp_valid, one cycle
// control   csr_index, csr_wdata                    csr_valid & csr_ready
//
// a sample word that does not close a group does not make the block busy; one that does
// waits for the serial divider.
// an average query walks one history row a cycle, then divides.
// a gradient query counts its steps one a cycle, reads two rows and divides.
// after reset the history memory is zeroed one entry a cycle, all
// HISTORY_DEPTH * 2^clog2(NUM_BINS) entries (32768 by default), busy held high.
// the response side cannot stall; results are strobed for one cycle.

module spectrum_history_bin_averager_top #(
   parameter int HISTORY_DEPTH   = 128,
   parameter int NUM_BINS        = 256,
   parameter int GRADIENT_WINDOW = 100
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire [1:0]                          req_type,
   input  wire signed [15:0]                  req_sample_i,
   input  wire signed [15:0]                  req_sample_q,
   input  wire                                req_last_sample,
   input  wire [7:0]                          req_bin_index,
   input  wire [7:0]                          req_frame_count,
   output logic                               rsp_valid,
   output logic signed [18:0]                 rsp_query_value,
   output logic [7:0]                         rsp_rows_used,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [shab_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [15:0]                         csr_wdata
);

   import shab_pkg::*;

   localparam int RW   = $clog2(HISTORY_DEPTH);
   localparam int BW   = $clog2(NUM_BINS);
   localparam int AW   = RW + BW;
   localparam int MD   = HISTORY_DEPTH * (1 << BW);
   localparam int MAXN = (HISTORY_DEPTH > GRADIENT_WINDOW) ? HISTORY_DEPTH : GRADIENT_WINDOW;
   localparam int CW   = $clog2(MAXN + 1);
   localparam int SUMW = CELL_W + CW + 1;
   localparam int DW   = (SUMW > GSUM_W) ? SUMW : GSUM_W;
   localparam int DVW  = (CW > FACTOR_W) ? CW : FACTOR_W;

   // configuration registers
   logic [FACTOR_W-1:0]        decim_ff;
   logic signed [SAMPLE_W-1:0] offset_ff;
   logic                       swap_ff;

   // control and ring state
   state_type                  state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [RW-1:0]              newest_ff, newest_in;
   logic [RW-1:0]              oldest_ff, oldest_in;
   logic [BW:0]                wbin_ff, wbin_in;
   logic signed [GSUM_W-1:0]   gsum_ff, gsum_in;
   logic [FACTOR_W-1:0]        gfill_ff, gfill_in;
   logic                       last_ff, last_in;

   // query walk
   logic [RW-1:0]              z_ff, z_in;
   logic [RW-1:0]              arow_ff, arow_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [CW-1:0]              lim_ff, lim_in;
   logic signed [SUMW-1:0]     sum_ff, sum_in;
   logic signed [CELL_W-1:0]   aval_ff, aval_in;
   logic                       pend_ff, pend_in;
   logic [BW-1:0]              bin_ff, bin_in;
   logic                       binok_ff, binok_in;

   // response
   logic                       rv_ff, rv_in;
   logic signed [VALUE_W-1:0]  rval_ff, rval_in;
   logic [ROWS_W-1:0]          rrows_ff, rrows_in;

   // memory and divider hookup
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr, mem_raddr;
   logic [CELL_W-1:0]          mem_wdata, mem_rdata;
   logic                       div_start, div_done;
   logic signed [DW-1:0]       div_dividend, div_quot;
   logic [DVW-1:0]             div_divisor;

   // helper values
   logic                       accept;
   logic signed [SAMPLE_W-1:0] q_sel;
   logic signed [GSUM_W-1:0]   fsum;
   logic [FACTOR_W-1:0]        fill1, feff;
   logic                       close_grp;
   logic [RW-1:0]              z_prev, newest_prev, newest_next, oldest_next;
   logic [CW-1:0]              n1;
   logic signed [CELL_W-1:0]   rd_level;
   logic signed [CELL_W-1:0]   store_val;
   logic [CW+ROWS_W-1:0]       rows_wide;
   logic                       walk_end, grad_end;

   function automatic logic [RW-1:0] row_before(input logic [RW-1:0] r);
      logic [RW-1:0] res;
      res = (r == '0) ? RW'(HISTORY_DEPTH - 1) : (r - 1'b1);
      return res;
   endfunction

   function automatic logic [RW-1:0] row_after(input logic [RW-1:0] r);
      logic [RW-1:0] res;
      res = (r == RW'(HISTORY_DEPTH - 1)) ? '0 : (r + 1'b1);
      return res;
   endfunction

   shab_ram #(.WIDTH(CELL_W), .DEPTH(MD)) u_hist (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   shab_div #(.DW(DW), .DVW(DVW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // configuration writes, taken at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff  <= FACTOR_W'(1);
         offset_ff <= '0;
         swap_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECIM:  decim_ff  <= csr_wdata[FACTOR_W-1:0];
            CSR_OFFSET: offset_ff <= signed'(csr_wdata);
            CSR_SWAP:   swap_ff   <= csr_wdata[0];
            default:    ;
         endcase
      end
   end

   // shared helper terms
   always_comb begin
      accept      = start && !busy;
      q_sel       = swap_ff ? req_sample_i : req_sample_q;
      fsum        = gsum_ff + GSUM_W'(q_sel);
      fill1       = gfill_ff + 1'b1;
      feff        = (decim_ff == '0) ? FACTOR_W'(1) : decim_ff;
      close_grp   = (fill1 >= feff) || req_last_sample;
      z_prev      = row_before(z_ff);
      n1          = n_ff + 1'b1;
      newest_prev = row_before(newest_ff);
      newest_next = row_after(newest_ff);
      oldest_next = (newest_next == oldest_ff) ? row_after(oldest_ff) : oldest_ff;
      rd_level    = binok_ff ? signed'(mem_rdata) : '0;
      store_val   = CELL_W'(div_quot) + CELL_W'(offset_ff);
      rows_wide   = {{ROWS_W{1'b0}}, n_ff};
      walk_end    = (z_prev == oldest_ff) || (n1 >= lim_ff);
      grad_end    = (n1 >= CW'(GRADIENT_WINDOW)) || (z_prev == oldest_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_ff == AW'(MD - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_SAMPLE: if (close_grp) state_in = ST_GRP_DIV;
                  REQ_AVG:    state_in = ST_AVG_WALK;
                  REQ_GRAD:   state_in = ST_GRD_WALK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_GRP_DIV:   if (div_done) state_in = ST_IDLE;
         ST_AVG_WALK:  if (walk_end) state_in = ST_AVG_DRAIN;
         ST_AVG_DRAIN: state_in = ST_Q_DIV;
         ST_GRD_WALK:  if (grad_end) state_in = ST_GRD_RDA;
         ST_GRD_RDA:   state_in = ST_GRD_RDB;
         ST_GRD_RDB:   state_in = ST_GRD_SUM;
         ST_GRD_SUM:   state_in = ST_Q_DIV;
         ST_Q_DIV:     if (div_done) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   // memory, divider and busy controls
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      mem_raddr    = {z_prev, bin_ff};
      div_start    = 1'b0;
      div_dividend = DW'(fsum);
      div_divisor  = DVW'(feff);
      unique case (state_ff)
         ST_CLEAR: mem_we = 1'b1;
         ST_IDLE: begin
            div_start = accept && (req_type == REQ_SAMPLE) && close_grp;
         end
         ST_GRP_DIV: begin
            mem_we    = div_done && (wbin_ff < (BW + 1)'(NUM_BINS));
            mem_waddr = {newest_ff, wbin_ff[BW-1:0]};
            mem_wdata = store_val;
         end
         ST_AVG_DRAIN: begin
            div_start    = 1'b1;
            div_dividend = DW'(sum_in);
            div_divisor  = DVW'(n_ff);
         end
         ST_GRD_RDA: mem_raddr = {arow_ff, bin_ff};
         ST_GRD_RDB: mem_raddr = {z_ff, bin_ff};
         ST_GRD_SUM: begin
            div_start    = 1'b1;
            div_dividend = DW'(SUMW'(aval_ff) - SUMW'(rd_level));
            div_divisor  = DVW'(n_ff);
         end
         default: ;
      endcase
   end

   // register next values
   always_comb begin
      clr_in    = clr_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      wbin_in   = wbin_ff;
      gsum_in   = gsum_ff;
      gfill_in  = gfill_ff;
      last_in   = last_ff;
      z_in      = z_ff;
      arow_in   = arow_ff;
      n_in      = n_ff;
      lim_in    = lim_ff;
      sum_in    = sum_ff;
      aval_in   = aval_ff;
      pend_in   = 1'b0;
      bin_in    = bin_ff;
      binok_in  = binok_ff;
      rv_in     = 1'b0;
      rval_in   = rval_ff;
      rrows_in  = rrows_ff;
      if (pend_ff) begin
         sum_in = sum_ff + SUMW'(rd_level);
      end
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            if (accept) begin
               bin_in   = req_bin_index[BW-1:0];
               binok_in = {1'b0, req_bin_index} < 9'(NUM_BINS);
               n_in     = '0;
               sum_in   = '0;
               z_in     = newest_ff;
               if ((req_frame_count == '0) || (int'(req_frame_count) > HISTORY_DEPTH)) begin
                  lim_in = CW'(HISTORY_DEPTH);
               end else begin
                  lim_in = CW'(req_frame_count);
               end
               if (req_type == REQ_GRAD) begin
                  z_in = newest_prev;
               end
               if (req_type == REQ_SAMPLE) begin
                  last_in = req_last_sample;
                  if (close_grp) begin
                     gsum_in  = '0;
                     gfill_in = '0;
                  end else begin
                     gsum_in  = fsum;
                     gfill_in = fill1;
                  end
               end
            end
         end
         ST_GRP_DIV: begin
            if (div_done) begin
               if (wbin_ff < (BW + 1)'(NUM_BINS)) begin
                  wbin_in = wbin_ff + 1'b1;
               end
               if (last_ff) begin
                  newest_in = newest_next;
                  oldest_in = oldest_next;
                  wbin_in   = '0;
               end
            end
         end
         ST_AVG_WALK: begin
            z_in    = z_prev;
            n_in    = n1;
            pend_in = 1'b1;
         end
         ST_GRD_WALK: begin
            z_in = z_prev;
            n_in = n1;
            if (n_ff == '0) begin
               arow_in = z_prev;
            end
         end
         ST_GRD_SUM: aval_in = aval_ff;
         ST_Q_DIV: begin
            if (div_done) begin
               rv_in    = 1'b1;
               rval_in  = div_quot[VALUE_W-1:0];
               rrows_in = rows_wide[ROWS_W-1:0];
            end
         end
         default: ;
      endcase
      // first gradient row lands while the second is being read
      if (state_ff == ST_GRD_RDB) begin
         aval_in = rd_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         wbin_ff   <= '0;
         gsum_ff   <= '0;
         gfill_ff  <= '0;
         pend_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         wbin_ff   <= wbin_in;
         gsum_ff   <= gsum_in;
         gfill_ff  <= gfill_in;
         pend_ff   <= pend_in;
         rv_ff     <= rv_in;
      end
      last_ff  <= last_in;
      z_ff     <= z_in;
      arow_ff  <= arow_in;
      n_ff     <= n_in;
      lim_ff   <= lim_in;
      sum_ff   <= sum_in;
      aval_ff  <= aval_in;
      bin_ff   <= bin_in;
      binok_ff <= binok_in;
      rval_ff  <= rval_in;
      rrows_ff <= rrows_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_query_value = rval_ff;
   assign rsp_rows_used   = rrows_ff;

   // checks
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_Q_DIV) && $past(div_done))
      else $error("response without a finished division");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_GRP_DIV))
      else $error("history write outside clear or group store");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && ((req_type == REQ_AVG) || (req_type == REQ_GRAD))) |=> busy)
      else $error("query accepted without going busy");

   a_wbin_range: assert property (@(posedge clock) disable iff (reset)
      wbin_ff <= (BW + 1)'(NUM_BINS))
      else $error("write bin beyond row");

endmodule

`default_nettype wire

>>> test/shab_checker.sv
`timescale 1ns / 1ps

module shab_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire               busy,
   input  wire [1:0]         req_type,
   input  wire signed [15:0] req_sample_i,
   input  wire signed [15:0] req_sample_q,
   input  wire               req_last_sample,
   input  wire [7:0]         req_bin_index,
   input  wire [7:0]         req_frame_count,
   input  wire               rsp_valid,
   input  wire signed [18:0] rsp_query_value,
   input  wire [7:0]         rsp_rows_used,
   input  wire               csr_valid,
   input  wire               csr_ready,
   input  wire [shab_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [15:0]        csr_wdata,
   output int                pending,
   output int                errors,
   output int                words_seen,
   output int                answers_seen
);

   import shab_pkg::*;

   localparam int ROWS   = 128;
   localparam int BINS   = 256;
   localparam int GRAD_W = 100;

   typedef struct packed {
      logic signed [18:0] level;
      logic [7:0]         rows;
   } answer_type;

   answer_type answer_q[$];

   // model copy of the history and the registers
   int       hist [ROWS][BINS];
   int       newest, oldest, wbin, gfill;
   longint   gsum;
   int       decim;
   int       offset;
   bit       swap;

   function automatic int prev_row(input int r);
      return (r == 0) ? ROWS - 1 : r - 1;
   endfunction

   function automatic int level_at(input int row, input int b);
      if (b >= BINS || row >= ROWS) return 0;
      return hist[row][b];
   endfunction

   // close the current group into the next bin of the newest row
   task automatic close_group();
      int f;
      f = (decim == 0) ? 1 : decim;
      if (wbin < BINS) begin
         hist[newest][wbin] = int'(gsum / f + offset);
         wbin++;
      end
      gsum  = 0;
      gfill = 0;
   endtask

   task automatic apply_word(input logic [1:0] t, input logic signed [15:0] si,
                             input logic signed [15:0] sq, input logic last,
                             input logic [7:0] b, input logic [7:0] cnt);
      int         f, n, z, z2, lim;
      longint     total, v;
      answer_type a;
      total = 0;
      n     = 0;
      case (t)
         REQ_SAMPLE: begin
            f = (decim == 0) ? 1 : decim;
            gsum += swap ? si : sq;
            gfill++;
            if (gfill >= f || last) close_group();
            if (last) begin
               newest = (newest + 1) % ROWS;
               if (newest == oldest) oldest = (oldest + 1) % ROWS;
               wbin = 0;
            end
         end
         REQ_AVG: begin
            lim = (cnt == 0 || cnt > ROWS) ? ROWS : cnt;
            z   = newest;
            do begin
               z = prev_row(z);
               total += level_at(z, b);
               n++;
            end while (z != oldest && n < lim);
         end
         REQ_GRAD: begin
            z  = newest;
            z2 = prev_row(z);
            do begin
               z  = prev_row(z);
               z2 = prev_row(z2);
               if (n > 0) total += longint'(level_at(z, b)) - longint'(level_at(z2, b));
               n++;
               if (n >= GRAD_W) break;
            end while (z2 != oldest);
         end
         default: ;
      endcase
      if (t == REQ_AVG || t == REQ_GRAD) begin
         v       = total / n;
         a.level = v[18:0];
         a.rows  = n[7:0];
         answer_q.push_back(a);
      end
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         foreach (hist[r, c]) hist[r][c] = 0;
         newest = 0; oldest = 0; wbin = 0; gfill = 0; gsum = 0;
         decim = 1; offset = 0; swap = 0;
         answer_q.delete();
         errors = 0; words_seen = 0; answers_seen = 0;
      end else begin
         // compare result word with oldest expectation
         if (rsp_valid) begin
            answers_seen++;
            if (answer_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result expected none actual %0d/%0d",
                        $time, rsp_query_value, rsp_rows_used);
            end else begin
               a = answer_q.pop_front();
               if (rsp_query_value !== a.level) begin
                  errors++;
                  $display("%0t: query_value expected %0d actual %0d",
                           $time, a.level, rsp_query_value);
               end
               if (rsp_rows_used !== a.rows) begin
                  errors++;
                  $display("%0t: rows_used expected %0d actual %0d",
                           $time, a.rows, rsp_rows_used);
               end
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DECIM:  decim  = csr_wdata[6:0];
               CSR_OFFSET: offset = $signed(csr_wdata);
               CSR_SWAP:   swap   = csr_wdata[0];
               default: ;
            endcase
         end
         // accepted request word
         if (start && !busy) begin
            words_seen++;
            apply_word(req_type, req_sample_i, req_sample_q, req_last_sample,
                       req_bin_index, req_frame_count);
         end
      end
      // answers still owed
      pending = answer_q.size();
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import shab_pkg::*;

   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0] req_type = REQ_SAMPLE;
   logic signed [15:0] req_sample_i = '0, req_sample_q = '0;
   logic req_last_sample = 1'b0;
   logic [7:0] req_bin_index = '0, req_frame_count = '0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DECIM;
   logic [15:0] csr_wdata = '0;
   wire busy, rsp_valid, csr_ready;
   wire signed [18:0] rsp_query_value;
   wire [7:0] rsp_rows_used;
   int pending, errors, words_seen, answers_seen;
   int idle_pct = 0;
   int csr_writes = 0;

   always #5 clock = ~clock;

   spectrum_history_bin_averager_top dut (
      .clock, .reset, .start, .busy, .req_type, .req_sample_i, .req_sample_q,
      .req_last_sample, .req_bin_index, .req_frame_count, .rsp_valid,
      .rsp_query_value, .rsp_rows_used, .csr_valid, .csr_ready, .csr_index,
      .csr_wdata
   );

   shab_checker chk (
      .clock, .reset, .start, .busy, .req_type, .req_sample_i, .req_sample_q,
      .req_last_sample, .req_bin_index, .req_frame_count, .rsp_valid,
      .rsp_query_value, .rsp_rows_used, .csr_valid, .csr_ready, .csr_index,
      .csr_wdata, .pending, .errors, .words_seen, .answers_seen
   );

   // one request word, with random idle cycles ahead of it
   task automatic send_word(input logic [1:0] t, input logic signed [15:0] si,
                            input logic signed [15:0] sq, input logic last,
                            input logic [7:0] b, input logic [7:0] cnt);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_type = t; req_sample_i = si; req_sample_q = sq;
      req_last_sample = last; req_bin_index = b; req_frame_count = cnt;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
   endtask

   // wait for every answer, let a pending divide finish
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_valid = 1'b1; csr_index = idx; csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   task automatic rand_sample(input logic last);
      send_word(REQ_SAMPLE, 16'($urandom), 16'($urandom), last,
                8'($urandom), 8'($urandom));
   endtask

   task automatic rand_query(input logic [1:0] t);
      logic [7:0] b, cnt;
      b   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      cnt = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(0, 4));
      send_word(t, 16'($urandom), 16'($urandom), 1'($urandom), b, cnt);
   endtask

   // mostly whole frames with random content, some queries and noise
   task automatic random_phase(input int words, input int long_ok);
      int sent, len, r;
      sent = 0;
      while (sent < words) begin
         r = $urandom_range(99);
         if (r < 70) begin
            len = (long_ok != 0 && $urandom_range(59) == 0) ? 260 : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) rand_sample(k == len - 1);
            sent += len;
         end else begin
            if (r < 86)      rand_query(REQ_AVG);
            else if (r < 96) rand_query(REQ_GRAD);
            else if (r < 98) rand_query(REQ_SPARE);
            else             rand_sample(1'($urandom));
            sent++;
         end
         if (sent > words / 2 && sent < words / 2 + 10) drain();
      end
      drain();
   endtask

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: zero factor, extreme offset, swapped samples
      write_reg(CSR_DECIM, 16'd0);
      write_reg(CSR_OFFSET, 16'h8000);
      write_reg(CSR_SWAP, 16'd1);
      send_word(REQ_AVG, 0, 0, 0, 8'd0, 8'd0);
      send_word(REQ_GRAD, 0, 0, 0, 8'd255, 8'd0);
      send_word(REQ_SAMPLE, 16'h7fff, 16'h8000, 0, 0, 0);
      send_word(REQ_SAMPLE, 16'h8000, 16'h7fff, 1, 8'hff, 8'hff);
      send_word(REQ_SPARE, 16'h7fff, 16'h7fff, 1, 8'd0, 8'd1);
      send_word(REQ_AVG, 0, 0, 0, 8'd0, 8'd200);
      send_word(REQ_AVG, 0, 0, 0, 8'd1, 8'd1);
      send_word(REQ_GRAD, 0, 0, 0, 8'd0, 8'd3);
      drain();
      // directed: factor above the usual range, partial group
      write_reg(CSR_DECIM, 16'd127);
      write_reg(CSR_OFFSET, 16'h7fff);
      write_reg(CSR_SWAP, 16'd0);
      for (int k = 0; k < 5; k++) send_word(REQ_SAMPLE, 16'h8000, 16'h8000, 0, 0, 0);
      send_word(REQ_SAMPLE, 16'h8000, 16'h8000, 1, 0, 0);
      send_word(REQ_AVG, 0, 0, 0, 8'd0, 8'd128);
      send_word(REQ_GRAD, 0, 0, 0, 8'd0, 8'd0);
      drain();

      // random phases with different settings and idle rates
      write_reg(CSR_DECIM, 16'd1);
      write_reg(CSR_OFFSET, 16'($urandom));
      idle_pct = 7;
      random_phase(330, 1);
      write_reg(CSR_DECIM, 16'd64);
      write_reg(CSR_OFFSET, 16'h7fff);
      write_reg(CSR_SWAP, 16'd1);
      idle_pct = 72;
      random_phase(330, 0);
      write_reg(CSR_DECIM, 16'($urandom_range(2, 5)));
      write_reg(CSR_OFFSET, 16'($urandom));
      write_reg(CSR_SWAP, 16'($urandom_range(1)));
      idle_pct = 0;
      random_phase(330, 1);

      drain();
      repeat (200) @(negedge clock);
      $display("covered %0d request words, %0d query answers, %0d register writes",
               words_seen, answers_seen, csr_writes);
      $display("settings: decimation 0/1/64/127 and mid, offset extremes, both iq orders");
      if (errors == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
